// ===== rtl/core/isfc_pkg.sv =====
package isfc_pkg;

    typedef enum logic [2:0] {
        MODE_PASS      = 3'd0,
        MODE_CF32_CS16 = 3'd1,
        MODE_CF32_CS12 = 3'd2,
        MODE_CS16_CS12 = 3'd3,
        MODE_CS16_CS8  = 3'd4,
        MODE_CF32_CS8  = 3'd5,
        MODE_CF32_CU8  = 3'd6
    } isfc_mode_t;

    localparam logic DIR_RX = 1'b0;
    localparam logic DIR_TX = 1'b1;

    localparam logic [1:0] REG_DIRECTION  = 2'd0;
    localparam logic [1:0] REG_CONV_MODE  = 2'd1;
    localparam logic [1:0] REG_SCALE_BITS = 2'd2;
    localparam logic [1:0] REG_ELEM_BYTES = 2'd3;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

    // one multiplier lane: unpacked operands plus any special result
    typedef struct packed {
        logic        sign;
        logic        special;
        logic [31:0] special_bits;
        logic [8:0]  esum;
        logic [23:0] ma;
        logic [23:0] mb;
    } isfc_lane_t;

    // side data that travels beside the multiplier lanes
    typedef struct packed {
        logic        last;
        logic        dir;
        logic [2:0]  mode;
        logic [63:0] raw;
    } isfc_side_t;

    // cs12 packing: byte0 = i[11:4], byte1 = q[7:4]:i[15:12], byte2 = q[15:8]
    function automatic logic [23:0] pack12(input logic [15:0] i, input logic [15:0] q);
        return {q[15:8], q[7:4], i[15:12], i[11:4]};
    endfunction

endpackage

// ===== rtl/core/iq_sample_format_converter_unit.sv =====
// stages from request accept to result valid: unpack, multiply, normalize,
// round, format
// throughput: one request per cycle; the whole pipeline holds while the
// output result is stalled
// reset: valid bits cleared, registers return to receive / passthrough,
// scale 1.0, 4 bytes per element
module iq_sample_format_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] wire_word,
    input  logic [31:0] host_i,
    input  logic [31:0] host_q,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] wire_out,
    output logic [31:0] host_i_out,
    output logic [31:0] host_q_out,
    output logic        last_out,
    output logic        clipped
);

    logic        direction_reg;
    logic [2:0]  conv_mode_reg;
    logic [31:0] scale_bits_reg;
    logic [3:0]  elem_bytes_reg;
    logic [4:0]  vld_reg, vld_next;
    logic        en;
    logic        wr;

    isfc_pkg::isfc_lane_t lane_i;
    isfc_pkg::isfc_lane_t lane_q;
    isfc_pkg::isfc_side_t side_s1;
    isfc_pkg::isfc_side_t side_s2_reg;
    isfc_pkg::isfc_side_t side_s3_reg;
    isfc_pkg::isfc_side_t side_s4_reg;
    logic [31:0]          fi;
    logic [31:0]          fq;

    assign pready    = 1'b1;
    assign wr        = psel & penable & pwrite;
    assign en        = ~(vld_reg[4] & out_stall);
    assign in_stall  = ~en;
    assign out_valid = vld_reg[4];
    assign vld_next  = {vld_reg[3:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= isfc_pkg::DIR_RX;
            conv_mode_reg  <= isfc_pkg::MODE_PASS;
            scale_bits_reg <= isfc_pkg::SCALE_RESET;
            elem_bytes_reg <= 4'd4;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                isfc_pkg::REG_DIRECTION:  direction_reg  <= pwdata[0];
                isfc_pkg::REG_CONV_MODE:  conv_mode_reg  <= pwdata[2:0];
                isfc_pkg::REG_SCALE_BITS: scale_bits_reg <= pwdata;
                isfc_pkg::REG_ELEM_BYTES: elem_bytes_reg <= pwdata[3:0];
                default:                  elem_bytes_reg <= elem_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            isfc_pkg::REG_DIRECTION:  prdata = {31'd0, direction_reg};
            isfc_pkg::REG_CONV_MODE:  prdata = {29'd0, conv_mode_reg};
            isfc_pkg::REG_SCALE_BITS: prdata = scale_bits_reg;
            isfc_pkg::REG_ELEM_BYTES: prdata = {28'd0, elem_bytes_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 5'd0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_s2_reg <= side_s1;
            side_s3_reg <= side_s2_reg;
            side_s4_reg <= side_s3_reg;
        end
    end

    isfc_unpack u_unpack (
        .clk        (clk),
        .en         (en),
        .dir        (direction_reg),
        .mode       (conv_mode_reg),
        .scale_bits (scale_bits_reg),
        .elem_bytes (elem_bytes_reg),
        .wire_word  (wire_word),
        .host_i     (host_i),
        .host_q     (host_q),
        .last_in    (last_in),
        .lane_i     (lane_i),
        .lane_q     (lane_q),
        .side       (side_s1)
    );

    isfc_fmul u_fmul_i (
        .clk    (clk),
        .en     (en),
        .lane   (lane_i),
        .result (fi)
    );

    isfc_fmul u_fmul_q (
        .clk    (clk),
        .en     (en),
        .lane   (lane_q),
        .result (fq)
    );

    isfc_pack u_pack (
        .clk        (clk),
        .en         (en),
        .side       (side_s4_reg),
        .fi         (fi),
        .fq         (fq),
        .wire_out   (wire_out),
        .host_i_out (host_i_out),
        .host_q_out (host_q_out),
        .last_out   (last_out),
        .clipped    (clipped)
    );

endmodule

// ===== rtl/core/isfc_unpack.sv =====
module isfc_unpack (
    input  logic                   clk,
    input  logic                   en,
    input  logic                   dir,
    input  logic [2:0]             mode,
    input  logic [31:0]            scale_bits,
    input  logic [3:0]             elem_bytes,
    input  logic [63:0]            wire_word,
    input  logic [31:0]            host_i,
    input  logic [31:0]            host_q,
    input  logic                   last_in,
    output isfc_pkg::isfc_lane_t   lane_i,
    output isfc_pkg::isfc_lane_t   lane_q,
    output isfc_pkg::isfc_side_t   side
);

    function automatic isfc_pkg::isfc_lane_t make_lane(
        input logic               tx,
        input logic [31:0]        h,
        input logic signed [16:0] v,
        input logic [31:0]        s
    );
        isfc_pkg::isfc_lane_t l;
        logic        a_sign;
        logic [7:0]  ea;
        logic [23:0] ma;
        logic        a_nan;
        logic        a_inf;
        logic        a_zero;
        logic [16:0] mag;
        logic [7:0]  eb;
        logic        s_nan;
        logic        s_inf;
        logic        s_zero;
        mag = v[16] ? 17'(-v) : 17'(v);
        if (tx == isfc_pkg::DIR_RX)
        begin
            a_sign = v[16];
            ea     = 8'd150;
            ma     = {8'b0, mag[15:0]};
            a_nan  = 1'b0;
            a_inf  = 1'b0;
            a_zero = (mag == 17'd0);
        end
        else
        begin
            a_sign = h[31];
            ea     = (h[30:23] == 8'd0) ? 8'd1 : h[30:23];
            ma     = {(h[30:23] != 8'd0), h[22:0]};
            a_nan  = (h[30:23] == 8'hFF) && (h[22:0] != 23'd0);
            a_inf  = (h[30:23] == 8'hFF) && (h[22:0] == 23'd0);
            a_zero = (h[30:0] == 31'd0);
        end
        eb     = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
        s_nan  = (s[30:23] == 8'hFF) && (s[22:0] != 23'd0);
        s_inf  = (s[30:23] == 8'hFF) && (s[22:0] == 23'd0);
        s_zero = (s[30:0] == 31'd0);

        l.sign    = a_sign ^ s[31];
        l.esum    = {1'b0, ea} + {1'b0, eb};
        l.ma      = ma;
        l.mb      = {(s[30:23] != 8'd0), s[22:0]};
        l.special = a_nan | s_nan | a_inf | s_inf;
        if (a_nan)
            l.special_bits = h | isfc_pkg::QNAN_BIT;
        else if (s_nan)
            l.special_bits = s | isfc_pkg::QNAN_BIT;
        else if ((a_inf && s_zero) || (s_inf && a_zero))
            l.special_bits = isfc_pkg::DEFAULT_NAN;
        else
            l.special_bits = {l.sign, 8'hFF, 23'd0};
        return l;
    endfunction

    isfc_pkg::isfc_lane_t lane_i_reg, lane_i_next;
    isfc_pkg::isfc_lane_t lane_q_reg, lane_q_next;
    isfc_pkg::isfc_side_t side_reg, side_next;

    logic [15:0]        i12;
    logic [15:0]        q12;
    logic signed [16:0] v_i;
    logic signed [16:0] v_q;
    logic [63:0]        bmask;
    logic [3:0]         nbytes;

    always_comb
    begin
        i12    = {wire_word[11:8], wire_word[7:0], 4'b0};
        q12    = {wire_word[23:16], wire_word[15:12], 4'b0};
        nbytes = (elem_bytes > 4'd8) ? 4'd8 : elem_bytes;
        for (int k = 0; k < 8; k++)
            bmask[8*k +: 8] = (4'(k) < nbytes) ? 8'hFF : 8'h00;

        case (mode)
            isfc_pkg::MODE_CF32_CS16:
            begin
                v_i = {wire_word[15], wire_word[15:0]};
                v_q = {wire_word[31], wire_word[31:16]};
            end
            isfc_pkg::MODE_CF32_CS12:
            begin
                v_i = {i12[15], i12};
                v_q = {q12[15], q12};
            end
            isfc_pkg::MODE_CF32_CS8:
            begin
                v_i = {{9{wire_word[7]}}, wire_word[7:0]};
                v_q = {{9{wire_word[15]}}, wire_word[15:8]};
            end
            isfc_pkg::MODE_CF32_CU8:
            begin
                v_i = $signed({9'b0, wire_word[7:0]}) - 17'sd127;
                v_q = $signed({9'b0, wire_word[15:8]}) - 17'sd127;
            end
            default:
            begin
                v_i = 17'sd0;
                v_q = 17'sd0;
            end
        endcase

        side_next.last = last_in;
        side_next.dir  = dir;
        side_next.mode = mode;
        side_next.raw  = 64'd0;
        if (dir == isfc_pkg::DIR_RX)
        begin
            case (mode)
                isfc_pkg::MODE_PASS:
                    side_next.raw = wire_word & bmask;
                isfc_pkg::MODE_CS16_CS12:
                    side_next.raw = {{16{q12[15]}}, q12, {16{i12[15]}}, i12};
                isfc_pkg::MODE_CS16_CS8:
                    side_next.raw = {{24{wire_word[15]}}, wire_word[15:8],
                                     {24{wire_word[7]}}, wire_word[7:0]};
                default:
                    side_next.raw = 64'd0;
            endcase
        end
        else
        begin
            case (mode)
                isfc_pkg::MODE_PASS:
                    side_next.raw = {host_q, host_i} & bmask;
                isfc_pkg::MODE_CS16_CS12:
                    side_next.raw = {40'd0, isfc_pkg::pack12(host_i[15:0], host_q[15:0])};
                isfc_pkg::MODE_CS16_CS8:
                    side_next.raw = {48'd0, host_q[7:0], host_i[7:0]};
                default:
                    side_next.raw = 64'd0;
            endcase
        end

        lane_i_next = make_lane(dir, host_i, v_i, scale_bits);
        lane_q_next = make_lane(dir, host_q, v_q, scale_bits);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_i_reg <= lane_i_next;
            lane_q_reg <= lane_q_next;
            side_reg   <= side_next;
        end
    end

    assign lane_i = lane_i_reg;
    assign lane_q = lane_q_reg;
    assign side   = side_reg;

endmodule

// ===== rtl/core/isfc_fmul.sv =====
module isfc_fmul (
    input  logic                 clk,
    input  logic                 en,
    input  isfc_pkg::isfc_lane_t lane,
    output logic [31:0]          result
);

    // multiply stage
    logic [47:0] prod_reg;
    logic [8:0]  esum_m_reg;
    logic        sign_m_reg;
    logic        spec_m_reg;
    logic [31:0] sbits_m_reg;

    // normalize stage
    logic [47:0]        prod_n_reg;
    logic signed [10:0] sh_reg, sh_next;
    logic [9:0]         eb_reg, eb_next;
    logic               zero_reg, zero_next;
    logic               sign_n_reg;
    logic               spec_n_reg;
    logic [31:0]        sbits_n_reg;

    // round stage
    logic [31:0] result_reg, result_next;

    logic [5:0]         lead;
    logic signed [10:0] e_val;
    logic signed [10:0] extra;

    always_comb
    begin
        lead = 6'd0;
        for (int k = 0; k < 48; k++)
            if (prod_reg[k])
                lead = 6'(k);
        zero_next = (prod_reg == 48'd0);
        e_val     = $signed({5'b0, lead}) + $signed({2'b0, esum_m_reg}) - 11'sd173;
        extra     = (e_val < 11'sd1) ? (11'sd1 - e_val) : 11'sd0;
        sh_next   = $signed({5'b0, lead}) - 11'sd23 + extra;
        eb_next   = (e_val < 11'sd1) ? 10'd0 : (e_val[9:0] - 10'd1);
    end

    logic [7:0]  sh_u;
    logic [4:0]  sh_l;
    logic [47:0] shifted;
    logic        guard;
    logic        sticky;
    logic [24:0] q;
    logic [32:0] mag;
    logic [47:0] low_mask;
    logic [10:0] sh_neg;

    always_comb
    begin
        sh_neg   = 11'(-sh_reg);
        sh_l     = sh_neg[4:0];
        sh_u     = sh_reg[7:0];
        low_mask = 48'd0;
        guard    = 1'b0;
        sticky   = 1'b0;
        if (sh_reg[10])
            shifted = prod_n_reg << sh_l;
        else
        begin
            shifted = prod_n_reg >> sh_u;
            if (sh_u != 8'd0 && sh_u <= 8'd48)
            begin
                guard    = prod_n_reg[6'(sh_u - 8'd1)];
                low_mask = (48'd1 << (sh_u - 8'd1)) - 48'd1;
                sticky   = |(prod_n_reg & low_mask);
            end
            else if (sh_u > 8'd48)
                sticky = |prod_n_reg;
        end
        q   = shifted[24:0] + {24'd0, guard & (sticky | shifted[0])};
        mag = {eb_reg, 23'd0} + {8'd0, q};

        if (spec_n_reg)
            result_next = sbits_n_reg;
        else if (zero_reg)
            result_next = {sign_n_reg, 31'd0};
        else if (mag[32:23] >= 10'd255)
            result_next = {sign_n_reg, 8'hFF, 23'd0};
        else
            result_next = {sign_n_reg, mag[30:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= lane.ma * lane.mb;
            esum_m_reg  <= lane.esum;
            sign_m_reg  <= lane.sign;
            spec_m_reg  <= lane.special;
            sbits_m_reg <= lane.special_bits;

            prod_n_reg  <= prod_reg;
            sh_reg      <= sh_next;
            eb_reg      <= eb_next;
            zero_reg    <= zero_next;
            sign_n_reg  <= sign_m_reg;
            spec_n_reg  <= spec_m_reg;
            sbits_n_reg <= sbits_m_reg;

            result_reg  <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/isfc_pack.sv =====
module isfc_pack (
    input  logic                 clk,
    input  logic                 en,
    input  isfc_pkg::isfc_side_t side,
    input  logic [31:0]          fi,
    input  logic [31:0]          fq,
    output logic [63:0]          wire_out,
    output logic [31:0]          host_i_out,
    output logic [31:0]          host_q_out,
    output logic                 last_out,
    output logic                 clipped
);

    typedef struct packed {
        logic        clip;
        logic [16:0] val;
    } isfc_conv_t;

    // truncate toward zero, saturate at the given limits
    function automatic isfc_conv_t f2i(
        input logic [31:0] r,
        input logic [16:0] lim_p,
        input logic [16:0] lim_n,
        input logic [16:0] hi,
        input logic [16:0] lo
    );
        isfc_conv_t  c;
        logic [16:0] t;
        logic [23:0] m;
        m = {1'b1, r[22:0]};
        if (r[30:23] < 8'd127)
            t = 17'd0;
        else if (r[30:23] >= 8'd144)
            t = 17'h1FFFF;
        else
            t = 17'(m >> (8'd150 - r[30:23]));
        c.clip = 1'b0;
        if (r[30:23] == 8'hFF && r[22:0] != 23'd0)
        begin
            c.clip = 1'b1;
            c.val  = 17'd0;
        end
        else if (!r[31])
        begin
            if (t >= lim_p)
            begin
                c.clip = 1'b1;
                c.val  = hi;
            end
            else
                c.val = t;
        end
        else
        begin
            if (t >= lim_n)
            begin
                c.clip = 1'b1;
                c.val  = lo;
            end
            else
                c.val = 17'(-t);
        end
        return c;
    endfunction

    logic [63:0] wire_out_reg, wire_out_next;
    logic [31:0] host_i_out_reg, host_i_out_next;
    logic [31:0] host_q_out_reg, host_q_out_next;
    logic        last_out_reg;
    logic        clipped_reg, clipped_next;

    logic [16:0] lim_p;
    logic [16:0] lim_n;
    logic [16:0] hi;
    logic [16:0] lo;
    isfc_conv_t  ci;
    isfc_conv_t  cq;
    logic [16:0] ui;
    logic [16:0] uq;

    always_comb
    begin
        case (side.mode)
            isfc_pkg::MODE_CF32_CS8:
            begin
                lim_p = 17'd128;
                lim_n = 17'd129;
                hi    = 17'd127;
                lo    = 17'h1FF80;
            end
            isfc_pkg::MODE_CF32_CU8:
            begin
                lim_p = 17'd129;
                lim_n = 17'd128;
                hi    = 17'd128;
                lo    = 17'h1FF81;
            end
            default:
            begin
                lim_p = 17'd32768;
                lim_n = 17'd32769;
                hi    = 17'd32767;
                lo    = 17'h18000;
            end
        endcase
        ci = f2i(fi, lim_p, lim_n, hi, lo);
        cq = f2i(fq, lim_p, lim_n, hi, lo);
        ui = ci.val + 17'd127;
        uq = cq.val + 17'd127;

        wire_out_next   = 64'd0;
        host_i_out_next = 32'd0;
        host_q_out_next = 32'd0;
        clipped_next    = 1'b0;
        if (side.dir == isfc_pkg::DIR_RX)
        begin
            case (side.mode) inside
                isfc_pkg::MODE_CF32_CS16, isfc_pkg::MODE_CF32_CS12,
                isfc_pkg::MODE_CF32_CS8, isfc_pkg::MODE_CF32_CU8:
                begin
                    host_i_out_next = fi;
                    host_q_out_next = fq;
                end
                default:
                begin
                    host_i_out_next = side.raw[31:0];
                    host_q_out_next = side.raw[63:32];
                end
            endcase
        end
        else
        begin
            case (side.mode)
                isfc_pkg::MODE_CF32_CS16:
                begin
                    wire_out_next = {32'd0, cq.val[15:0], ci.val[15:0]};
                    clipped_next  = ci.clip | cq.clip;
                end
                isfc_pkg::MODE_CF32_CS12:
                begin
                    wire_out_next = {40'd0, isfc_pkg::pack12(ci.val[15:0], cq.val[15:0])};
                    clipped_next  = ci.clip | cq.clip;
                end
                isfc_pkg::MODE_CF32_CS8:
                begin
                    wire_out_next = {48'd0, cq.val[7:0], ci.val[7:0]};
                    clipped_next  = ci.clip | cq.clip;
                end
                isfc_pkg::MODE_CF32_CU8:
                begin
                    wire_out_next = {48'd0, uq[7:0], ui[7:0]};
                    clipped_next  = ci.clip | cq.clip;
                end
                default:
                    wire_out_next = side.raw;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wire_out_reg   <= wire_out_next;
            host_i_out_reg <= host_i_out_next;
            host_q_out_reg <= host_q_out_next;
            last_out_reg   <= side.last;
            clipped_reg    <= clipped_next;
        end
    end

    assign wire_out   = wire_out_reg;
    assign host_i_out = host_i_out_reg;
    assign host_q_out = host_q_out_reg;
    assign last_out   = last_out_reg;
    assign clipped    = clipped_reg;

endmodule
